FILE: design/pacs_pkg.sv
// shared types and constants for the paddle axis calibrate/scale block
// no dependencies; imported by pacs_div and the top level

package pacs_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_LOW   = 3'd0,
		REG_LEFT_HIGH  = 3'd1,
		REG_RIGHT_LOW  = 3'd2,
		REG_RIGHT_HIGH = 3'd3,
		REG_INVERT     = 3'd4,
		REG_INDEP      = 3'd5,
		REG_BITE       = 3'd6
	} cfg_reg_t;

	// item kinds carried in tuser
	typedef enum logic [1:0] {
		MODE_SAMPLE    = 2'd0,
		MODE_CAL_START = 2'd1,
		MODE_CAL_STOP  = 2'd2,
		MODE_UNUSED    = 2'd3
	} mode_t;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_NUM  = 7'b0001000,
		ST_LOAD = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	// percent scale of the bite point
	localparam logic [6:0] PCT_FULL = 7'd100;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

FILE: design/pacs_prep.sv
// range clamp and invert for one paddle sample
// purely combinational; no package dependencies

module pacs_prep #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] raw,
	input  logic [SAMPLE_BITS-1:0] lo,
	input  logic [SAMPLE_BITS-1:0] hi,
	input  logic                   inv,
	output logic [SAMPLE_BITS-1:0] n,
	output logic [SAMPLE_BITS-1:0] d
);

	logic [SAMPLE_BITS-1:0] span;
	logic [SAMPLE_BITS-1:0] pos;
	logic [SAMPLE_BITS-1:0] pos_cl;

	always_comb begin
		span   = hi - lo;
		pos    = (raw <= lo) ? '0 : (raw - lo);
		pos_cl = (pos > span) ? span : pos;
		if (hi > lo) begin
			d = span;
			n = inv ? (span - pos_cl) : pos_cl;
		end else begin
			// empty range: fraction zero before inversion
			d = SAMPLE_BITS'(1);
			n = inv ? SAMPLE_BITS'(1) : '0;
		end
	end

endmodule

FILE: design/pacs_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// uses pacs_pkg for the control and status structs

module pacs_div
	import pacs_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  div_ctl_t                     ctl,
	input  logic [2*SAMPLE_BITS+8:0]     dividend,
	input  logic [SAMPLE_BITS+7:0]       divisor,
	output div_sts_t                     sts,
	output logic [SAMPLE_BITS-1:0]       quotient
);

	localparam int DW  = SAMPLE_BITS + 8;
	localparam int CNW = $clog2(SAMPLE_BITS + 1);

	logic [DW-1:0]          rem_q;
	logic [SAMPLE_BITS-1:0] low_q;
	logic [DW-1:0]          dvs_q;
	logic [CNW-1:0]         cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DW:0]            trial;
	logic                   qbit;
	logic [DW:0]            diff;

	always_comb begin
		trial = {rem_q, low_q[SAMPLE_BITS-1]};
		qbit  = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNW'(1);
				if (cnt_q == CNW'(SAMPLE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; upper dividend bits are known to stay below the divisor
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= dividend[SAMPLE_BITS+DW-1:SAMPLE_BITS];
			low_q <= dividend[SAMPLE_BITS-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			low_q <= {low_q[SAMPLE_BITS-2:0], qbit};
		end
	end

	assign sts.done = done_q;
	assign quotient = low_q;

endmodule

FILE: design/paddle_axis_calibrate_scale.sv
// top level of the paddle axis calibrate/scale block
// depends on pacs_pkg, pacs_prep and pacs_div

// Usage
// - s_axis: one word per item. tuser carries the item kind (sample pair,
//   calibration start, calibration stop); tdata carries the two paddle samples.
// - m_axis: one word per sample pair with both axes and both scaled paddles.
//   calibration commands and the unused kind give no word.
// - cfg: write channel (cfg_valid/cfg_ready, cfg_index, cfg_data), always
//   ready; write only while no sample is in flight. writing either range
//   register of a side drops that side's learned range.
// - path: a sample pair gives its word once both paddles have passed, in turn,
//   through PREP, MUL, NUM, LOAD and the serial divider that both paddles
//   share, one quotient bit per cycle; with a bite of 100 or more the
//   divider is skipped and each paddle ends at LOAD.
// - flow: one item at a time; the next item can be accepted once the
//   word is loaded into the output register.
// - a finished word sits in the output register; the next item is accepted
//   meanwhile, and only its result waits if the receiver still stalls.
// - reset: configuration to its defaults (full range, bite 50 percent,
//   combined axes, no invert), calibration off, learned ranges cleared.

module paddle_axis_calibrate_scale
	import pacs_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// sample input: tuser = mode; tdata = left_sample, right_sample
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [1:0]                              s_axis_tuser,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// result output: tdata = axis_x, axis_y, left_scaled, right_scaled
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]                    cfg_index,
	input  logic [((SAMPLE_BITS > 8) ? SAMPLE_BITS : 8)-1:0] cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int OUT_W = ((4*SAMPLE_BITS+7)/8)*8;
	localparam int NW    = 2*SAMPLE_BITS + 9;   // dividend width
	localparam int DW    = SAMPLE_BITS + 8;     // doubled denominator width
	localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};

	// configuration registers
	logic [SB-1:0] cfg_lo_q [2];
	logic [SB-1:0] cfg_hi_q [2];
	logic [1:0]    invert_q;
	logic          indep_q;
	logic [7:0]    bite_q;

	// calibration state per side
	logic          cal_q      [2];
	logic [SB-1:0] seen_min_q [2];
	logic [SB-1:0] seen_max_q [2];
	logic [SB-1:0] learn_lo_q [2];
	logic [SB-1:0] learn_hi_q [2];
	logic          learn_ok_q [2];

	// sequencer and datapath
	state_t        state_q;
	logic          side_q;
	logic [SB-1:0] raw_q    [2];
	logic [SB-1:0] sc_q     [2];
	logic [SB-1:0] n_q;
	logic [SB-1:0] d_q;
	logic [SB+6:0] num100_q;
	logic [SB+6:0] d100_q;
	logic [SB+7:0] lowcut_q;
	logic [SB+6:0] num_q;
	logic [SB+6:0] den_q;

	// output register
	logic          out_vld_q;
	logic [SB-1:0] ax_q;
	logic [SB-1:0] ay_q;
	logic [SB-1:0] ls_q;
	logic [SB-1:0] rs_q;

	logic          in_acc;
	logic          cfg_acc;
	mode_t         mode;
	logic [SB-1:0] in_raw [2];
	logic [SB-1:0] use_lo;
	logic [SB-1:0] use_hi;
	logic [SB-1:0] prep_n;
	logic [SB-1:0] prep_d;
	logic          bite_big;
	logic [SB+7:0] cut_num;
	logic [SB+6:0] den_c;
	logic [SB+6:0] num_c;
	logic [NW-1:0] dividend;
	logic [DW-1:0] divisor;
	div_ctl_t      div_ctl;
	div_sts_t      div_sts;
	logic [SB-1:0] quot;
	logic          out_free;
	logic [SB-1:0] sc_max;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign mode          = mode_t'(s_axis_tuser);
	assign in_raw[0]     = s_axis_tdata[SB-1:0];
	assign in_raw[1]     = s_axis_tdata[2*SB-1:SB];
	assign bite_big      = (bite_q >= {1'b0, PCT_FULL});
	assign out_free      = !out_vld_q || m_axis_tready;

	// range in use: learned range once adopted, else the host range
	always_comb begin
		use_lo = learn_ok_q[side_q] ? learn_lo_q[side_q] : cfg_lo_q[side_q];
		use_hi = learn_ok_q[side_q] ? learn_hi_q[side_q] : cfg_hi_q[side_q];
	end

	pacs_prep #(
		.SAMPLE_BITS(SB)
	) u_prep (
		.raw (raw_q[side_q]),
		.lo  (use_lo),
		.hi  (use_hi),
		.inv (invert_q[side_q]),
		.n   (prep_n),
		.d   (prep_d)
	);

	// fraction numerator/denominator after the bite point is removed
	always_comb begin
		cut_num = ((SB+8)'(num100_q) <= lowcut_q) ? '0 : ((SB+8)'(num100_q) - lowcut_q);
		den_c   = (SB+7)'((SB+8)'(d100_q) - lowcut_q);
		num_c   = (cut_num > (SB+8)'(den_c)) ? den_c : cut_num[SB+6:0];
	end

	// rounded quotient: (2*FULL*num + den) / (2*den)
	always_comb begin
		dividend = (NW'(num_q) << (SB + 1)) - (NW'(num_q) << 1) + NW'(den_q);
		divisor  = {den_q, 1'b0};
		div_ctl.start = (state_q == ST_LOAD) && !bite_big;
	end

	pacs_div #(
		.SAMPLE_BITS(SB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.divisor  (divisor),
		.sts      (div_sts),
		.quotient (quot)
	);

	// configuration registers and learned-range bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				cfg_lo_q[i]   <= '0;
				cfg_hi_q[i]   <= FULL;
				cal_q[i]      <= 1'b0;
				seen_min_q[i] <= FULL;
				seen_max_q[i] <= '0;
				learn_lo_q[i] <= '0;
				learn_hi_q[i] <= FULL;
				learn_ok_q[i] <= 1'b0;
			end
			invert_q <= '0;
			indep_q  <= 1'b0;
			bite_q   <= 8'd50;
		end else begin
			if (in_acc) begin
				unique case (mode)
					MODE_CAL_START: begin
						for (int i = 0; i < 2; i++) begin
							cal_q[i]      <= 1'b1;
							seen_min_q[i] <= FULL;
							seen_max_q[i] <= '0;
						end
					end
					MODE_CAL_STOP: begin
						for (int i = 0; i < 2; i++) begin
							if (cal_q[i]) begin
								cal_q[i] <= 1'b0;
								// adopt only a non-empty learned range
								if (seen_max_q[i] >= seen_min_q[i]) begin
									learn_lo_q[i] <= seen_min_q[i];
									learn_hi_q[i] <= seen_max_q[i];
									learn_ok_q[i] <= 1'b1;
								end
							end
						end
					end
					MODE_SAMPLE: begin
						for (int i = 0; i < 2; i++) begin
							if (cal_q[i]) begin
								if (in_raw[i] < seen_min_q[i]) seen_min_q[i] <= in_raw[i];
								if (in_raw[i] > seen_max_q[i]) seen_max_q[i] <= in_raw[i];
							end
						end
					end
					MODE_UNUSED: begin
					end
					default: begin
					end
				endcase
			end
			if (cfg_acc) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_LEFT_LOW: begin
						cfg_lo_q[0]   <= cfg_data[SB-1:0];
						learn_ok_q[0] <= 1'b0;
					end
					REG_LEFT_HIGH: begin
						cfg_hi_q[0]   <= cfg_data[SB-1:0];
						learn_ok_q[0] <= 1'b0;
					end
					REG_RIGHT_LOW: begin
						cfg_lo_q[1]   <= cfg_data[SB-1:0];
						learn_ok_q[1] <= 1'b0;
					end
					REG_RIGHT_HIGH: begin
						cfg_hi_q[1]   <= cfg_data[SB-1:0];
						learn_ok_q[1] <= 1'b0;
					end
					REG_INVERT: invert_q <= cfg_data[1:0];
					REG_INDEP:  indep_q  <= cfg_data[0];
					REG_BITE:   bite_q   <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// sequencer: left paddle, then right paddle, through the shared divider unless the bite is 100 or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			side_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (mode == MODE_SAMPLE)) begin
						side_q  <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_NUM;
				ST_NUM:  state_q <= ST_LOAD;
				ST_LOAD: begin
					if (bite_big) begin
						side_q  <= 1'b1;
						state_q <= side_q ? ST_OUT : ST_PREP;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						side_q  <= 1'b1;
						state_q <= side_q ? ST_OUT : ST_PREP;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word valid: set when a word is loaded, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign sc_max = (sc_q[0] > sc_q[1]) ? sc_q[0] : sc_q[1];

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && (mode == MODE_SAMPLE)) begin
			raw_q[0] <= in_raw[0];
			raw_q[1] <= in_raw[1];
		end
		if (state_q == ST_PREP) begin
			n_q <= prep_n;
			d_q <= prep_d;
		end
		if (state_q == ST_MUL) begin
			num100_q <= (SB+7)'(n_q) * (SB+7)'(PCT_FULL);
			d100_q   <= (SB+7)'(d_q) * (SB+7)'(PCT_FULL);
			lowcut_q <= (SB+8)'(d_q) * (SB+8)'(bite_q);
		end
		if (state_q == ST_NUM) begin
			num_q <= num_c;
			den_q <= den_c;
		end
		if ((state_q == ST_LOAD) && bite_big) sc_q[side_q] <= '0;
		if ((state_q == ST_DIV) && div_sts.done) sc_q[side_q] <= quot;
		if ((state_q == ST_OUT) && out_free) begin
			ax_q <= indep_q ? sc_q[0] : sc_max;
			ay_q <= indep_q ? sc_q[1] : sc_max;
			ls_q <= sc_q[0];
			rs_q <= sc_q[1];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'({rs_q, ls_q, ay_q, ax_q});

endmodule
